// ===== rtl/bbs_pkg.sv =====
// Shared types and constants for the 3x3 brush box smoothing block.
// Holds the register map, the register bank layout and the pipeline control group.
// No dependencies.
package bbs_pkg;

   localparam int RADIUS_W    = 6;
   localparam int RSQ_W       = 28;
   localparam int FRAC_W      = 8;
   localparam int OFFSET_W    = 7;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 28;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LOOP_RADIUS = 3'd0,
      CSR_RADIUS_SQ   = 3'd1,
      CSR_FRAC_X      = 3'd2,
      CSR_FRAC_Y      = 3'd3,
      CSR_CIRCULAR    = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [RADIUS_W-1:0] loop_radius;
      logic [RSQ_W-1:0]    radius_sq;
      logic [FRAC_W-1:0]   frac_x;
      logic [FRAC_W-1:0]   frac_y;
      logic                circular;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      loop_radius: 6'd1,
      radius_sq:   28'd65536,
      frac_x:      8'd0,
      frac_y:      8'd0,
      circular:    1'b1
   };

   // load enables of the three pipeline register groups
   typedef struct packed {
      logic a_load;
      logic b_load;
      logic out_load;
   } pipe_ctl_type;

endpackage

// ===== rtl/bbs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Used for the two row stores; no dependencies.
module bbs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/bbs_window.sv =====
// Raster position counters, two row stores and the 3x3 window cells.
// Produces the nine-sample sum and position of each interior result.
// Depends on bbs_pkg and bbs_ram.
module bbs_window #(
   parameter int HEIGHT_BITS = 16,
   parameter int MAX_SIDE    = 128
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                accept,
   input  logic signed [HEIGHT_BITS-1:0]       height,
   input  logic [bbs_pkg::RADIUS_W-1:0]        loop_radius,
   output logic                                produce,
   output logic signed [HEIGHT_BITS+3:0]       sum,
   output logic [$clog2(MAX_SIDE)-1:0]         pos_col,
   output logic [$clog2(MAX_SIDE)-1:0]         pos_row,
   output logic                                last
);
   import bbs_pkg::*;

   localparam int CW   = $clog2(MAX_SIDE);
   localparam int SW_A = $clog2(MAX_SIDE + 1);
   localparam int SW   = (SW_A > RADIUS_W + 2) ? SW_A : RADIUS_W + 2;
   localparam int HB   = HEIGHT_BITS;

   logic [CW-1:0] col_count_ff, col_count_in;
   logic [CW-1:0] row_count_ff, row_count_in;
   logic [HB-1:0] cells_ff [6];

   logic [SW-1:0] side_raw, side, col_p1, row_p1;
   logic          end_col, end_row;
   logic [CW-1:0] col_next, row_next;
   logic [HB-1:0] up1, up2;
   logic signed [HB+3:0] terms [9];

   always_comb begin
      side_raw = SW'({loop_radius, 1'b0}) + SW'(2);
      side     = (side_raw > SW'(MAX_SIDE)) ? SW'(MAX_SIDE) : side_raw;
      col_p1   = SW'(col_count_ff) + SW'(1);
      row_p1   = SW'(row_count_ff) + SW'(1);
      end_col  = (col_p1 >= side);
      end_row  = (row_p1 >= side);
      col_next = end_col ? '0 : col_p1[CW-1:0];
      if (end_col) begin
         row_next = end_row ? '0 : row_p1[CW-1:0];
      end else begin
         row_next = row_count_ff;
      end
      col_count_in = accept ? col_next : col_count_ff;
      row_count_in = accept ? row_next : row_count_ff;
   end

   // read ahead at the column of the next beat so data is ready on acceptance
   bbs_ram #(.WIDTH(HB), .DEPTH(MAX_SIDE)) u_store_a (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (col_count_ff),
      .wr_data (height),
      .rd_addr (col_count_in),
      .rd_data (up1)
   );

   bbs_ram #(.WIDTH(HB), .DEPTH(MAX_SIDE)) u_store_b (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (col_count_ff),
      .wr_data (up1),
      .rd_addr (col_count_in),
      .rd_data (up2)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         col_count_ff <= '0;
         row_count_ff <= '0;
         for (int i = 0; i < 6; i++) begin
            cells_ff[i] <= '0;
         end
      end else if (accept) begin
         col_count_ff <= col_count_in;
         row_count_ff <= row_count_in;
         cells_ff[0]  <= cells_ff[3];
         cells_ff[1]  <= cells_ff[4];
         cells_ff[2]  <= cells_ff[5];
         cells_ff[3]  <= up2;
         cells_ff[4]  <= up1;
         cells_ff[5]  <= height;
      end
   end

   always_comb begin
      for (int i = 0; i < 6; i++) begin
         terms[i] = {{4{cells_ff[i][HB-1]}}, cells_ff[i]};
      end
      terms[6] = {{4{up2[HB-1]}}, up2};
      terms[7] = {{4{up1[HB-1]}}, up1};
      terms[8] = {{4{height[HB-1]}}, height};
      sum = ((terms[0] + terms[1]) + (terms[2] + terms[3]))
          + ((terms[4] + terms[5]) + (terms[6] + terms[7])) + terms[8];
   end

   assign produce = (row_count_ff >= CW'(2)) && (col_count_ff >= CW'(2));
   assign pos_col = col_count_ff - CW'(1);
   assign pos_row = row_count_ff - CW'(1);
   assign last    = end_col && end_row;

endmodule

// ===== rtl/bbs_calc.sv =====
// Result datapath: rounded mean of nine by reciprocal multiply, and the brush
// distance test. Three register groups: stage A, stage B and the result register.
// Depends on bbs_pkg.
module bbs_calc #(
   parameter int HEIGHT_BITS = 16,
   parameter int MAX_SIDE    = 128
) (
   input  logic                                clock,
   input  bbs_pkg::pipe_ctl_type               ctl,
   input  bbs_pkg::cfg_type                    cfg,
   input  logic signed [HEIGHT_BITS+3:0]       sum,
   input  logic [$clog2(MAX_SIDE)-1:0]         pos_col,
   input  logic [$clog2(MAX_SIDE)-1:0]         pos_row,
   input  logic                                last,
   output logic signed [HEIGHT_BITS-1:0]       smoothed_height,
   output logic [bbs_pkg::OFFSET_W-1:0]        col_offset,
   output logic [bbs_pkg::OFFSET_W-1:0]        row_offset,
   output logic                                write_enable,
   output logic                                last_out
);
   import bbs_pkg::*;

   localparam int HB  = HEIGHT_BITS;
   localparam int CW  = $clog2(MAX_SIDE);
   localparam int PW  = (CW > RADIUS_W + 1) ? CW : RADIUS_W + 1;
   localparam int DW  = PW + 10;
   localparam int DSW = 2 * DW + 1;
   localparam int VW  = HB + 4;
   // v = sum + 9*2^(HB-1) + 4 is never negative; floor(v/9) - 2^(HB-1) is the mean
   localparam logic [63:0]   BIAS_FULL  = 64'd9 * (64'd1 << (HEIGHT_BITS - 1)) + 64'd4;
   localparam logic [VW-1:0] BIAS       = BIAS_FULL[VW-1:0];
   localparam logic [63:0]   RECIP_FULL = (64'd1 << (HEIGHT_BITS + 4)) / 64'd9;
   localparam logic [HB:0]   RECIP      = RECIP_FULL[HB:0];

   // stage 0: brush offsets from the window center
   logic signed [DW-1:0] tx, ty, dx, dy;
   logic [CW+OFFSET_W-1:0] col_wide, row_wide;

   always_comb begin
      tx = $signed(DW'(cfg.loop_radius)) + $signed(DW'(1)) - $signed(DW'(pos_col));
      ty = $signed(DW'(cfg.loop_radius)) + $signed(DW'(1)) - $signed(DW'(pos_row));
      dx = (tx <<< 8) + $signed(DW'(cfg.frac_x));
      dy = (ty <<< 8) + $signed(DW'(cfg.frac_y));
      col_wide = {{OFFSET_W{1'b0}}, pos_col};
      row_wide = {{OFFSET_W{1'b0}}, pos_row};
   end

   // stage A
   logic signed [HB+3:0]  sum_a_ff;
   logic signed [DW-1:0]  dx_a_ff, dy_a_ff;
   logic [OFFSET_W-1:0]   col_a_ff, row_a_ff;
   logic                  last_a_ff;

   always_ff @(posedge clock) begin
      if (ctl.a_load) begin
         sum_a_ff  <= sum;
         dx_a_ff   <= dx;
         dy_a_ff   <= dy;
         col_a_ff  <= col_wide[OFFSET_W-1:0];
         row_a_ff  <= row_wide[OFFSET_W-1:0];
         last_a_ff <= last;
      end
   end

   // stage A to B: multiplies
   logic [VW-1:0]          v_a;
   logic [VW+HB:0]         prod_a;
   logic signed [2*DW-1:0] dx_sq, dy_sq;
   logic [DSW-1:0]         dist_a;

   always_comb begin
      v_a    = VW'($unsigned(sum_a_ff)) + BIAS;
      prod_a = v_a * RECIP;
      dx_sq  = dx_a_ff * dx_a_ff;
      dy_sq  = dy_a_ff * dy_a_ff;
      dist_a = DSW'($unsigned(dx_sq)) + DSW'($unsigned(dy_sq));
   end

   // stage B
   logic [VW-1:0]       v_b_ff;
   logic [HB-1:0]       q0_b_ff;
   logic [DSW-1:0]      dist_b_ff;
   logic [OFFSET_W-1:0] col_b_ff, row_b_ff;
   logic                last_b_ff;

   always_ff @(posedge clock) begin
      if (ctl.b_load) begin
         v_b_ff    <= v_a;
         q0_b_ff   <= prod_a[VW +: HB];
         dist_b_ff <= dist_a;
         col_b_ff  <= col_a_ff;
         row_b_ff  <= row_a_ff;
         last_b_ff <= last_a_ff;
      end
   end

   // stage B to result: the reciprocal quotient is low by at most one
   logic [VW-1:0] rem_b;
   logic [HB-1:0] q_b;
   logic [HB-1:0] mean_b;
   logic          inside_b;

   always_comb begin
      rem_b    = v_b_ff - (VW'(q0_b_ff) << 3) - VW'(q0_b_ff);
      q_b      = q0_b_ff + HB'(rem_b >= VW'(9));
      mean_b   = {~q_b[HB-1], q_b[HB-2:0]};
      inside_b = !cfg.circular || (dist_b_ff < DSW'(cfg.radius_sq));
   end

   logic [HB-1:0]       mean_ff;
   logic [OFFSET_W-1:0] col_ff, row_ff;
   logic                we_ff, last_ff;

   always_ff @(posedge clock) begin
      if (ctl.out_load) begin
         mean_ff <= mean_b;
         col_ff  <= col_b_ff;
         row_ff  <= row_b_ff;
         we_ff   <= inside_b;
         last_ff <= last_b_ff;
      end
   end

   assign smoothed_height = $signed(mean_ff);
   assign col_offset      = col_ff;
   assign row_offset      = row_ff;
   assign write_enable    = we_ff;
   assign last_out        = last_ff;

endmodule

// ===== rtl/brush_box_smooth_3x3.sv =====
// 3x3 box smoothing of a square brush window of terrain heights.
//
// req_*: one height sample per beat, the window of side 2*loop_radius+2
// (at most MAX_SIDE) in raster order. rsp_*: one beat per interior position,
// the rounded mean of its nine neighbors, its column and row in the window,
// the brush write flag and a last flag on the final position of the window.
// A result follows the sample below and to the right of its position.
// csr_*: register writes, taken at once, to be done while no beat is in flight.
//
// Throughput is one sample per clock while req_stall is low. An accepted
// sample's result passes through stage A, stage B (the 9x reciprocal
// multiply and the two squares) and the result register before it leaves.
// When rsp_stall is high the result holds and the two inner stages keep
// filling; req_stall rises only once stage A, stage B and the result register
// are all full. The row stores are read one column ahead so each sample finds
// its two upper neighbors ready. Reset clears the position counters, window
// cells, pipeline valids and registers to their defaults; no clearing pass
// runs and the first sample is accepted on the cycle after reset drops.
module brush_box_smooth_3x3 #(
   parameter int MAX_SIDE    = 128,
   parameter int HEIGHT_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [HEIGHT_BITS-1:0]       req_height,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [HEIGHT_BITS-1:0]       rsp_smoothed_height,
   output logic [bbs_pkg::OFFSET_W-1:0]        rsp_col_offset,
   output logic [bbs_pkg::OFFSET_W-1:0]        rsp_row_offset,
   output logic                                rsp_write_enable,
   output logic                                rsp_last,
   input  logic                                csr_wr_en,
   input  logic [bbs_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [bbs_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import bbs_pkg::*;

   localparam int CW = $clog2(MAX_SIDE);

   cfg_type      cfg_ff;
   pipe_ctl_type ctl;

   logic a_valid_ff, a_valid_in;
   logic b_valid_ff, b_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_ready, b_free, a_free, accept;

   logic                 produce, last;
   logic signed [HEIGHT_BITS+3:0] sum;
   logic [CW-1:0]        pos_col, pos_row;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_LOOP_RADIUS: cfg_ff.loop_radius <= csr_wdata[RADIUS_W-1:0];
            CSR_RADIUS_SQ:   cfg_ff.radius_sq   <= csr_wdata[RSQ_W-1:0];
            CSR_FRAC_X:      cfg_ff.frac_x      <= csr_wdata[FRAC_W-1:0];
            CSR_FRAC_Y:      cfg_ff.frac_y      <= csr_wdata[FRAC_W-1:0];
            CSR_CIRCULAR:    cfg_ff.circular    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // each stage advances when the one after it is empty or draining
   always_comb begin
      out_ready    = !rsp_valid_ff || !rsp_stall;
      b_free       = !b_valid_ff || out_ready;
      a_free       = !a_valid_ff || b_free;
      accept       = req_valid && a_free;
      ctl.a_load   = a_free;
      ctl.b_load   = b_free;
      ctl.out_load = out_ready;
      a_valid_in   = a_free ? (accept && produce) : a_valid_ff;
      b_valid_in   = b_free ? a_valid_ff : b_valid_ff;
      rsp_valid_in = out_ready ? b_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= a_valid_in;
         b_valid_ff   <= b_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   bbs_window #(.HEIGHT_BITS(HEIGHT_BITS), .MAX_SIDE(MAX_SIDE)) u_window (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .height      (req_height),
      .loop_radius (cfg_ff.loop_radius),
      .produce     (produce),
      .sum         (sum),
      .pos_col     (pos_col),
      .pos_row     (pos_row),
      .last        (last)
   );

   bbs_calc #(.HEIGHT_BITS(HEIGHT_BITS), .MAX_SIDE(MAX_SIDE)) u_calc (
      .clock           (clock),
      .ctl             (ctl),
      .cfg             (cfg_ff),
      .sum             (sum),
      .pos_col         (pos_col),
      .pos_row         (pos_row),
      .last            (last),
      .smoothed_height (rsp_smoothed_height),
      .col_offset      (rsp_col_offset),
      .row_offset      (rsp_row_offset),
      .write_enable    (rsp_write_enable),
      .last_out        (rsp_last)
   );

   assign req_stall = !a_free;
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/bbs_checker.sv =====
// Port-level checks for brush_box_smooth_3x3, attached by the bind below.
// Depends on bbs_pkg and the top-level port list.
module bbs_checker #(
   parameter int HEIGHT_BITS = 16
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic signed [HEIGHT_BITS-1:0]       req_height,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic signed [HEIGHT_BITS-1:0]       rsp_smoothed_height,
   input logic [bbs_pkg::OFFSET_W-1:0]        rsp_col_offset,
   input logic [bbs_pkg::OFFSET_W-1:0]        rsp_row_offset,
   input logic                                rsp_write_enable,
   input logic                                rsp_last
);

   // nothing is left in the pipeline after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat present after reset");

   // a free result side never backs up into the sample side
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || !rsp_stall) |-> !req_stall)
      else $error("sample side stalled while result side is free");

   // hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_smoothed_height)
         && $stable(rsp_col_offset) && $stable(rsp_row_offset)
         && $stable(rsp_write_enable) && $stable(rsp_last)))
      else $error("stalled result beat changed");

   // hold a stalled sample beat
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_stall) |=> (req_valid && $stable(req_height)))
      else $error("stalled sample beat changed");

endmodule

bind brush_box_smooth_3x3 bbs_checker #(.HEIGHT_BITS(HEIGHT_BITS)) u_bbs_checker (.*);

// ===== test/testbench.sv =====
// Self-checking bench for the 3x3 brush box smoothing block: drives height windows,
// predicts every smoothed position and compares each result beat field by field.
// Depends on bbs_pkg and brush_box_smooth_3x3 from the rtl folder.
`timescale 1ns / 1ps

module testbench;
   import bbs_pkg::*;

   localparam int MAX_SIDE     = 128;
   localparam int HEIGHT_BITS  = 16;
   localparam int RANDOM_ITEMS = 1250;
   localparam int QUIET_LIMIT  = 400;
   localparam logic signed [HEIGHT_BITS-1:0] HEIGHT_TOP    = 16'sh7FFF;
   localparam logic signed [HEIGHT_BITS-1:0] HEIGHT_BOTTOM = 16'sh8000;
   localparam logic [RSQ_W-1:0] RSQ_TOP = 28'hFFFFFFF;

   typedef enum {FILL_RANDOM, FILL_TOP, FILL_BOTTOM, FILL_NEAR_ZERO} fill_mode_type;

   typedef struct {
      logic signed [HEIGHT_BITS-1:0] height;
      logic [OFFSET_W-1:0]           col;
      logic [OFFSET_W-1:0]           row;
      logic                          write_enable;
      logic                          last;
   } smoothed_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [HEIGHT_BITS-1:0] req_height = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [HEIGHT_BITS-1:0] rsp_smoothed_height;
   logic [OFFSET_W-1:0] rsp_col_offset;
   logic [OFFSET_W-1:0] rsp_row_offset;
   logic rsp_write_enable;
   logic rsp_last;
   logic csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // shadow of the block: registers, row stores, window taps and position counters
   cfg_type brush_cfg = CFG_RESET;
   logic signed [HEIGHT_BITS-1:0] above_row [MAX_SIDE];
   logic signed [HEIGHT_BITS-1:0] two_above_row [MAX_SIDE];
   logic signed [HEIGHT_BITS-1:0] window_taps [6];
   int unsigned col_pos = 0;
   int unsigned row_pos = 0;

   logic signed [HEIGHT_BITS-1:0] height_queue [$];
   smoothed_beat_type expected_beats [$];
   smoothed_beat_type want;
   int mismatch_count = 0;
   int gap_left = 0;
   int stall_left = 0;
   int quiet_cycles = 0;
   int unsigned queued_heights = 0;
   logic idle_on = 1'b1;

   brush_box_smooth_3x3 #(
      .MAX_SIDE(MAX_SIDE),
      .HEIGHT_BITS(HEIGHT_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_height(req_height),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_smoothed_height(rsp_smoothed_height),
      .rsp_col_offset(rsp_col_offset),
      .rsp_row_offset(rsp_row_offset),
      .rsp_write_enable(rsp_write_enable),
      .rsp_last(rsp_last),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #6 clock = ~clock;

   initial begin
      for (int i = 0; i < MAX_SIDE; i++) begin
         above_row[i] = '0;
         two_above_row[i] = '0;
      end
      for (int i = 0; i < 6; i++) window_taps[i] = '0;
   end

   // Advance the shadow by one accepted sample and queue the result it yields.
   task automatic smooth_sample(input logic signed [HEIGHT_BITS-1:0] h);
      int unsigned side, c, r, ci, pc, pr;
      logic signed [HEIGHT_BITS-1:0] up1, up2;
      longint sum, num, mean, dx, dy;
      smoothed_beat_type beat;
      side = 2 * brush_cfg.loop_radius + 2;
      if (side > MAX_SIDE) side = MAX_SIDE;
      c = col_pos;
      r = row_pos;
      ci = (c < MAX_SIDE) ? c : MAX_SIDE - 1;
      up1 = above_row[ci];
      up2 = two_above_row[ci];
      if (r >= 2 && c >= 2) begin
         sum = longint'(h);
         sum += longint'(up1);
         sum += longint'(up2);
         for (int k = 0; k < 6; k++) sum += longint'(window_taps[k]);
         // round to nearest: floor((2*sum + 9) / 18)
         num = 2 * sum + 9;
         if (num >= 0) mean = num / 18;
         else mean = -((-num + 17) / 18);
         pc = c - 1;
         pr = r - 1;
         beat.height = mean[HEIGHT_BITS-1:0];
         beat.col = pc[OFFSET_W-1:0];
         beat.row = pr[OFFSET_W-1:0];
         if (!brush_cfg.circular) begin
            beat.write_enable = 1'b1;
         end else begin
            dx = longint'(brush_cfg.frac_x)
               + 256 * (longint'(brush_cfg.loop_radius) + 1 - longint'(pc));
            dy = longint'(brush_cfg.frac_y)
               + 256 * (longint'(brush_cfg.loop_radius) + 1 - longint'(pr));
            beat.write_enable = (dx * dx + dy * dy < longint'(brush_cfg.radius_sq));
         end
         beat.last = (c + 1 >= side) && (r + 1 >= side);
         expected_beats.push_back(beat);
      end
      two_above_row[ci] = up1;
      above_row[ci] = h;
      window_taps[0] = window_taps[3];
      window_taps[1] = window_taps[4];
      window_taps[2] = window_taps[5];
      window_taps[3] = up2;
      window_taps[4] = up1;
      window_taps[5] = h;
      if (c + 1 >= side) begin
         col_pos = 0;
         row_pos = (r + 1 >= side) ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
      end
   endtask

   // Sample driver: hold a stalled beat, otherwise feed the next height or idle.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else if (!(req_valid && req_stall)) begin
         if (req_valid) smooth_sample(req_height);
         if (gap_left > 0) begin
            gap_left = gap_left - 1;
            req_valid <= 1'b0;
         end else if (idle_on && $urandom_range(0, 11) == 0) begin
            gap_left = $urandom_range(0, 16);
            req_valid <= 1'b0;
         end else if (height_queue.size() != 0) begin
            req_valid <= 1'b1;
            req_height <= height_queue.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result monitor: check each accepted beat against the oldest expectation.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_beats.size() == 0) begin
               $error("unexpected result beat: col %0d row %0d height %0d",
                      rsp_col_offset, rsp_row_offset, rsp_smoothed_height);
               mismatch_count++;
            end else begin
               want = expected_beats.pop_front();
               if (rsp_smoothed_height !== want.height) begin
                  $error("smoothed_height: expected %0d, got %0d",
                         want.height, rsp_smoothed_height);
                  mismatch_count++;
               end
               if (rsp_col_offset !== want.col) begin
                  $error("col_offset: expected %0d, got %0d", want.col, rsp_col_offset);
                  mismatch_count++;
               end
               if (rsp_row_offset !== want.row) begin
                  $error("row_offset: expected %0d, got %0d", want.row, rsp_row_offset);
                  mismatch_count++;
               end
               if (rsp_write_enable !== want.write_enable) begin
                  $error("write_enable: expected %0b, got %0b",
                         want.write_enable, rsp_write_enable);
                  mismatch_count++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0b, got %0b", want.last, rsp_last);
                  mismatch_count++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left = stall_left - 1;
            rsp_stall <= 1'b1;
         end else if (idle_on && $urandom_range(0, 11) == 0) begin
            stall_left = $urandom_range(0, 16);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog: end the run when no beat moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles = quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_LOOP_RADIUS: brush_cfg.loop_radius = value[RADIUS_W-1:0];
         CSR_RADIUS_SQ:   brush_cfg.radius_sq = value[RSQ_W-1:0];
         CSR_FRAC_X:      brush_cfg.frac_x = value[FRAC_W-1:0];
         CSR_FRAC_Y:      brush_cfg.frac_y = value[FRAC_W-1:0];
         CSR_CIRCULAR:    brush_cfg.circular = value[0];
         default: ;
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   // Wait until every sample is in and every result is out, then let the pipe empty.
   task automatic settle();
      do @(negedge clock);
      while (height_queue.size() != 0 || req_valid || expected_beats.size() != 0);
      repeat (6) @(negedge clock);
   endtask

   function automatic fill_mode_type pick_fill();
      case ($urandom_range(0, 9))
         0: return FILL_TOP;
         1: return FILL_BOTTOM;
         2: return FILL_NEAR_ZERO;
         default: return FILL_RANDOM;
      endcase
   endfunction

   task automatic queue_heights(input int unsigned count, input fill_mode_type mode);
      logic signed [HEIGHT_BITS-1:0] h;
      for (int unsigned i = 0; i < count; i++) begin
         case (mode)
            FILL_TOP:       h = HEIGHT_TOP;
            FILL_BOTTOM:    h = HEIGHT_BOTTOM;
            FILL_NEAR_ZERO: h = HEIGHT_BITS'(int'($urandom_range(0, 8)) - 4);
            default:        h = HEIGHT_BITS'($urandom());
         endcase
         height_queue.push_back(h);
      end
      queued_heights += count;
   endtask

   initial begin
      int unsigned side, new_radius, rsq_top, finish_count, c, r;
      logic mid_window;
      int phase;
      phase = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings, side 4: top-left block at the top, the rest at the bottom,
      // so the first result is the top mean and the last rounds a negative sum.
      for (int i = 0; i < 4; i++)
         for (int j = 0; j < 4; j++)
            height_queue.push_back((i < 3 && j < 3) ? HEIGHT_TOP : HEIGHT_BOTTOM);
      settle();

      // Radius zero: side 2 has no interior position, so no result at all.
      write_reg(CSR_LOOP_RADIUS, 0);
      height_queue.push_back(HEIGHT_TOP);
      height_queue.push_back(HEIGHT_BOTTOM);
      height_queue.push_back(16'sd1);
      height_queue.push_back(-16'sd1);
      settle();
      queued_heights = 0;

      while (queued_heights < RANDOM_ITEMS) begin
         mid_window = (col_pos != 0 || row_pos != 0);
         idle_on = (queued_heights < RANDOM_ITEMS - 200)
                 ? ($urandom_range(0, 3) != 0) : 1'b0;
         // a window cut short may only shrink, so every store entry read was written
         if (mid_window) begin
            new_radius = $urandom_range(0, brush_cfg.loop_radius);
         end else begin
            case ($urandom_range(0, 9))
               0: new_radius = 0;
               1: new_radius = $urandom_range(5, 8);
               default: new_radius = $urandom_range(1, 4);
            endcase
         end
         write_reg(CSR_LOOP_RADIUS, CSR_DATA_W'(new_radius));
         if (phase == 0 || $urandom_range(0, 1)) begin
            rsq_top = (new_radius + 2) * (new_radius + 2) * 65536;
            if (rsq_top > RSQ_TOP) rsq_top = RSQ_TOP;
            case ($urandom_range(0, 7))
               0: write_reg(CSR_RADIUS_SQ, 0);
               1: write_reg(CSR_RADIUS_SQ, RSQ_TOP);
               default: write_reg(CSR_RADIUS_SQ, CSR_DATA_W'($urandom_range(0, rsq_top)));
            endcase
         end
         if (phase == 0 || $urandom_range(0, 1)) begin
            case ($urandom_range(0, 3))
               0: write_reg(CSR_FRAC_X, 0);
               1: write_reg(CSR_FRAC_X, 255);
               default: write_reg(CSR_FRAC_X, CSR_DATA_W'($urandom_range(0, 255)));
            endcase
         end
         if (phase == 0 || $urandom_range(0, 1)) begin
            case ($urandom_range(0, 3))
               0: write_reg(CSR_FRAC_Y, 0);
               1: write_reg(CSR_FRAC_Y, 255);
               default: write_reg(CSR_FRAC_Y, CSR_DATA_W'($urandom_range(0, 255)));
            endcase
         end
         if (phase == 0 || $urandom_range(0, 1))
            write_reg(CSR_CIRCULAR,
                      (phase == 0) ? '0 : CSR_DATA_W'($urandom_range(0, 1)));

         side = 2 * new_radius + 2;
         if (mid_window) begin
            // count the samples that close the interrupted window at the new side
            finish_count = 0;
            c = col_pos;
            r = row_pos;
            while (c != 0 || r != 0) begin
               finish_count++;
               if (c + 1 >= side) begin
                  c = 0;
                  r = (r + 1 >= side) ? 0 : r + 1;
               end else begin
                  c = c + 1;
               end
            end
            queue_heights(finish_count, pick_fill());
         end
         repeat ($urandom_range(1, 3)) queue_heights(side * side, pick_fill());
         if ($urandom_range(0, 5) == 0)
            queue_heights($urandom_range(1, side * side - 1), pick_fill());
         settle();
         phase++;
      end

      repeat (8) @(negedge clock);
      if (mismatch_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/bbs_pkg.sv
rtl/bbs_ram.sv
rtl/bbs_window.sv
rtl/bbs_calc.sv
rtl/brush_box_smooth_3x3.sv
rtl/bbs_checker.sv
test/testbench.sv
